@@ rtl/vga_text_glyph_pixel_lookup_assert.svh @@
// Assertion macros for the glyph pixel lookup block.
// Define ASSERT_OFF to compile the checks out.
`ifndef VGA_TEXT_GLYPH_PIXEL_LOOKUP_ASSERT_SVH
`define VGA_TEXT_GLYPH_PIXEL_LOOKUP_ASSERT_SVH
`ifndef ASSERT_OFF
`define VTG_ASSERT(name, expr) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("vtg: invariant violated");
`define VTG_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("vtg: sequence violated");
`else
`define VTG_ASSERT(name, expr)
`define VTG_ASSERT_NEXT(name, pre, post)
`endif
`endif

@@ rtl/vtg_pkg.sv @@
package vtg_pkg;

   localparam int PLANE_ADDR_BITS = 16;
   localparam int LOOKUP_ADDR_BITS = 16;
   localparam int FONT_BYTE_BITS = 8;
   localparam int CSR_DATA_BITS = 6;
   localparam int CSR_INDEX_BITS = 2;
   localparam int SET_BASE_SHIFT = 13;

   // Characters 0xC0..0xDF are the box drawing range that extends into the ninth column.
   localparam logic [7:0] BOX_RANGE_MASK = 8'hE0;
   localparam logic [7:0] BOX_RANGE_CODE = 8'hC0;
   localparam logic [4:0] ROW_MASK = 5'h1F;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MEMORY_MAPS = 2'd0,
      CSR_CHAR_MAP_SELECT = 2'd1,
      CSR_NINE_DOT = 2'd2,
      CSR_LINE_GRAPHICS = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic memory_maps_enabled;
      logic [5:0] char_map_select;
      logic nine_dot_mode;
      logic line_graphics_bit;
   } cfg_type;

   typedef struct packed {
      logic [LOOKUP_ADDR_BITS-1:0] addr;
      logic [2:0] bit_sel;
      logic force_zero;
   } lookup_type;

endpackage

@@ rtl/vtg_ram.sv @@
module vtg_ram #(
   parameter int WIDTH = vtg_pkg::FONT_BYTE_BITS,
   parameter int DEPTH = 1 << vtg_pkg::PLANE_ADDR_BITS
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/vtg_csr.sv @@
module vtg_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  write_enable,
   input  logic [vtg_pkg::CSR_INDEX_BITS-1:0]    index,
   input  logic [vtg_pkg::CSR_DATA_BITS-1:0]     write_data,
   output vtg_pkg::cfg_type                      cfg
);

   vtg_pkg::cfg_type cfg_ff;
   vtg_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_enable) begin
         unique case (vtg_pkg::csr_index_type'(index))
            vtg_pkg::CSR_MEMORY_MAPS:     cfg_in.memory_maps_enabled = write_data[0];
            vtg_pkg::CSR_CHAR_MAP_SELECT: cfg_in.char_map_select = write_data[5:0];
            vtg_pkg::CSR_NINE_DOT:        cfg_in.nine_dot_mode = write_data[0];
            vtg_pkg::CSR_LINE_GRAPHICS:   cfg_in.line_graphics_bit = write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.memory_maps_enabled <= 1'b0;
         cfg_ff.char_map_select <= '0;
         cfg_ff.nine_dot_mode <= 1'b1;
         cfg_ff.line_graphics_bit <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/vtg_addr.sv @@
module vtg_addr (
   input  vtg_pkg::cfg_type    cfg,
   input  logic [7:0]          attribute,
   input  logic [7:0]          character,
   input  logic [3:0]          column,
   input  logic [4:0]          row,
   output vtg_pkg::lookup_type lookup
);

   logic       use_set_a;
   logic [1:0] sel;
   logic       sel_hi;
   logic [2:0] set_base;
   logic       wide_column;
   logic       box_char;

   always_comb begin
      use_set_a = attribute[3];
      sel = use_set_a ? cfg.char_map_select[3:2] : cfg.char_map_select[1:0];
      sel_hi = use_set_a ? cfg.char_map_select[5] : cfg.char_map_select[4];
      set_base = cfg.memory_maps_enabled ? {sel, sel_hi} : 3'd0;

      // Base sits in bits 15:13; character*32 plus row fills the low 13 bits exactly.
      lookup.addr = {set_base, character, row & vtg_pkg::ROW_MASK};

      // Columns past the byte read its last bit, unless the ninth column is background.
      wide_column = column[3];
      box_char = (character & vtg_pkg::BOX_RANGE_MASK) == vtg_pkg::BOX_RANGE_CODE;
      lookup.bit_sel = wide_column ? 3'd0 : ~column[2:0];
      lookup.force_zero = wide_column && cfg.nine_dot_mode &&
                          (cfg.line_graphics_bit || !box_char);
   end

endmodule

@@ rtl/vga_text_glyph_pixel_lookup.sv @@
// Pipeline: an accepted lookup registers its read byte and its stage-one entry; stage
// one moves into the response register whenever it is free, and rsp shows it there.
// Throughput: one transaction per cycle while the response side keeps up, set by the single port of the font memory.
// A write transaction produces no response.
// Reset is synchronous and active high; it clears the pipeline and sets the
// registers to their defaults (nine-dot mode on). Font memory is not cleared.
`include "vga_text_glyph_pixel_lookup_assert.svh"

module vga_text_glyph_pixel_lookup #(
   parameter int PLANE_ADDR_BITS = vtg_pkg::PLANE_ADDR_BITS
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_op,
   input  logic [15:0]                        req_address,
   input  logic [7:0]                         req_data,
   input  logic [7:0]                         req_attribute,
   input  logic [7:0]                         req_character,
   input  logic [3:0]                         req_column,
   input  logic [4:0]                         req_row,

   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_pixel,

   input  logic                               csr_write_enable,
   input  logic [vtg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [vtg_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);

   localparam int PLANE_DEPTH = 1 << PLANE_ADDR_BITS;

   vtg_pkg::cfg_type    cfg;
   vtg_pkg::lookup_type lookup;

   // Every accepted transaction gets the memory port in its accept cycle: a write
   // stores its byte, a lookup starts its read. The read byte lands in the memory's
   // output register, and the lookup waits in stage one beside it.
   logic                       req_fire;
   logic                       ram_we;
   logic [PLANE_ADDR_BITS-1:0] ram_addr;
   logic [7:0]                 ram_rdata;

   logic       s1_valid_ff, s1_valid_in;
   logic [2:0] s1_bit_sel_ff;
   logic       s1_force_zero_ff;
   logic       s1_advance;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_pixel_ff;
   logic rsp_free;

   vtg_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .write_enable (csr_write_enable),
      .index        (csr_index),
      .write_data   (csr_write_data),
      .cfg          (cfg)
   );

   vtg_addr u_addr (
      .cfg       (cfg),
      .attribute (req_attribute),
      .character (req_character),
      .column    (req_column),
      .row       (req_row),
      .lookup    (lookup)
   );

   // The response register is free when empty or being drained this cycle.
   // Stage one moves into it whenever it is free; while stage one is stuck the
   // memory is not enabled, so its read data holds until the move happens.
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign s1_advance = s1_valid_ff && rsp_free;
   assign req_ready = !s1_valid_ff || rsp_free;
   assign req_fire = req_valid && req_ready;

   assign ram_we = req_op == vtg_pkg::OP_WRITE;
   assign ram_addr = ram_we ? req_address[PLANE_ADDR_BITS-1:0]
                            : lookup.addr[PLANE_ADDR_BITS-1:0];

   vtg_ram #(
      .WIDTH (vtg_pkg::FONT_BYTE_BITS),
      .DEPTH (PLANE_DEPTH)
   ) u_font_ram (
      .clock (clock),
      .en    (req_fire),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (req_data),
      .rdata (ram_rdata)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = req_op == vtg_pkg::OP_LOOKUP;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_bit_sel_ff <= lookup.bit_sel;
         s1_force_zero_ff <= lookup.force_zero;
      end
      // The pixel is the chosen bit of the glyph byte, or background for a
      // blanked ninth column.
      if (s1_advance) begin
         rsp_pixel_ff <= !s1_force_zero_ff && ram_rdata[s1_bit_sel_ff];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel = rsp_pixel_ff;

   // A lookup always lands in stage one; a write never leaves anything there.
   `VTG_ASSERT_NEXT(a_lookup_enters_stage,
      req_fire && req_op == vtg_pkg::OP_LOOKUP, s1_valid_ff)
   `VTG_ASSERT_NEXT(a_write_leaves_no_stage,
      req_fire && req_op == vtg_pkg::OP_WRITE, !s1_valid_ff)
   // A blanked ninth column must reach the response as background.
   `VTG_ASSERT_NEXT(a_blank_column_is_background,
      s1_advance && s1_force_zero_ff, rsp_valid_ff && !rsp_pixel_ff)

endmodule
